[rtl/aabso_pkg.sv]
// Shared types and register indexes for the box / segment overlap test.
// No dependencies; imported by aabox_segment_overlap_test.
package aabso_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_CENTER_X    = 2'd0;
  localparam logic [1:0] REG_CENTER_Y    = 2'd1;
  localparam logic [1:0] REG_HALF_LENGTH = 2'd2;
  localparam logic [1:0] REG_HALF_WIDTH  = 2'd3;

  // Final decision kind after folding the segment into the canonical octant
  typedef enum logic [2:0] {
    DEC_FALSE = 3'd0,  // region pair cannot touch the box
    DEC_TRUE  = 3'd1,  // region pair always touches (or not covered by the table)
    DEC_A_GE  = 3'd2,  // overlap iff cross product against corner A >= 0
    DEC_A_LE  = 3'd3,  // overlap iff cross product against corner A <= 0
    DEC_AB    = 3'd4   // overlap iff cross A > 0 and cross B <= 0
  } dec_e;

endpackage

[rtl/aabox_segment_overlap_test.sv]
// Top level of the axis-aligned box / line segment overlap test.
// Depends on aabso_pkg (decision codes, register indexes).
//
// Channel   | Ports                                   | Dir | Handshake
// ----------+-----------------------------------------+-----+---------------------------
// segment   | seg_start_x/y_i, seg_end_x/y_i          | in  | start high, busy low
// result    | overlaps_o                              | out | res_valid_o, one cycle
// config    | cfg_idx_i, cfg_wdata_i                  | in  | cfg_we_i, no wait
//
// Cycles: one segment beat may be taken every cycle; the result passes through
// four pipeline registers plus the output register after the accepting edge.
// The pipeline holds two multiply stages: squares for the distance bound in
// stage 2, cross products in stage 4.
// Reset clears the valid chain and the box registers (box = point at origin).
// busy is never raised; the receiver cannot stall, so nothing in the pipe waits.
module aabox_segment_overlap_test #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [COORD_BITS-1:0]        cfg_wdata_i,
  // segment beat
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] seg_start_x_i,
  input  logic signed [COORD_BITS-1:0] seg_start_y_i,
  input  logic signed [COORD_BITS-1:0] seg_end_x_i,
  input  logic signed [COORD_BITS-1:0] seg_end_y_i,
  // result beat
  output logic                         res_valid_o,
  output logic                         overlaps_o
);
  import aabso_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int XW = CW + 1;      // offsets from box center
  localparam int OW = CW + 2;      // midpoint sums, cross operands
  localparam int PW = 2 * OW;      // signed products
  localparam int SW = 2 * CW + 3;  // distance-bound sums

  // ---------------------------------------------------------------------------
  // Box registers
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] cx_q, cy_q;
  logic        [CW-2:0] hl_q, hw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      hl_q <= '0;
      hw_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER_X:    cx_q <= $signed(cfg_wdata_i);
        REG_CENTER_Y:    cy_q <= $signed(cfg_wdata_i);
        REG_HALF_LENGTH: hl_q <= cfg_wdata_i[CW-2:0];
        REG_HALF_WIDTH:  hw_q <= cfg_wdata_i[CW-2:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Valid chain
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vo_q <= v4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: offsets from the box center, doubled midpoint, direction
  // ---------------------------------------------------------------------------
  logic signed [XW-1:0] x1_d, y1_d, x2_d, y2_d, x1_q, y1_q, x2_q, y2_q;
  logic signed [OW-1:0] mx_d, my_d, mx_q, my_q;
  logic signed [XW-1:0] ddx_d, ddy_d, ddx_q, ddy_q;
  logic                 zero_d, zero_q;

  always_comb begin
    x1_d   = {seg_start_x_i[CW-1], seg_start_x_i} - {cx_q[CW-1], cx_q};
    y1_d   = {cy_q[CW-1], cy_q} - {seg_start_y_i[CW-1], seg_start_y_i};
    x2_d   = {seg_end_x_i[CW-1], seg_end_x_i} - {cx_q[CW-1], cx_q};
    y2_d   = {cy_q[CW-1], cy_q} - {seg_end_y_i[CW-1], seg_end_y_i};
    mx_d   = {{2{seg_start_x_i[CW-1]}}, seg_start_x_i}
           + {{2{seg_end_x_i[CW-1]}}, seg_end_x_i}
           - {cx_q[CW-1], cx_q, 1'b0};
    my_d   = {{2{seg_start_y_i[CW-1]}}, seg_start_y_i}
           + {{2{seg_end_y_i[CW-1]}}, seg_end_y_i}
           - {cy_q[CW-1], cy_q, 1'b0};
    ddx_d  = {seg_end_x_i[CW-1], seg_end_x_i} - {seg_start_x_i[CW-1], seg_start_x_i};
    ddy_d  = {seg_end_y_i[CW-1], seg_end_y_i} - {seg_start_y_i[CW-1], seg_start_y_i};
    zero_d = (seg_start_x_i == seg_end_x_i) && (seg_start_y_i == seg_end_y_i);
  end

  always_ff @(posedge clk_i) begin
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    x2_q   <= x2_d;
    y2_q   <= y2_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    ddx_q  <= ddx_d;
    ddy_q  <= ddy_d;
    zero_q <= zero_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: squares for the distance bound; region grid, fold, table lookup
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0]     mxp, myp;
  logic signed [2*XW-1:0]   dxp, dyp;
  logic        [2*CW-3:0]   hl2_d, hw2_d, hl2_q, hw2_q;
  logic        [SW-1:0]     mx2_q, my2_q;
  logic        [2*CW-1:0]   dx2_q, dy2_q;

  assign mxp   = mx_q * mx_q;
  assign myp   = my_q * my_q;
  assign dxp   = ddx_q * ddx_q;
  assign dyp   = ddy_q * ddy_q;
  assign hl2_d = hl_q * hl_q;
  assign hw2_d = hw_q * hw_q;

  logic signed [XW-1:0] fx1_d, fy1_d, fx2_d, fy2_d, fx1_q, fy1_q, fx2_q, fy2_q;
  logic        [CW-2:0] fbx_d, fby_d, fbx_q, fby_q;
  logic                 pin_d, inbox_d, aneg_d, pin_q, inbox_q, aneg_q;
  dec_e                 dec_d, dec_q;

  always_comb begin
    logic signed [XW-1:0] bxs, bys, tx;
    logic signed [1:0]    gx1, gy1, gx2, gy2, tg;
    logic        [CW-2:0] tb;
    bxs = {2'b00, hl_q};
    bys = {2'b00, hw_q};
    tx  = '0;
    tg  = 2'sd0;
    tb  = '0;

    // zero-length segment: inclusive point test on the start point
    pin_d = (x1_q >= -bxs) && (x1_q <= bxs) && (y1_q >= -bys) && (y1_q <= bys);

    // start: outside only when strictly beyond; end: already when on the side
    gx1 = (x1_q > bxs) ? 2'sd1 : ((x1_q < -bxs) ? -2'sd1 : 2'sd0);
    gy1 = (y1_q > bys) ? 2'sd1 : ((y1_q < -bys) ? -2'sd1 : 2'sd0);
    gx2 = (x2_q >= bxs) ? 2'sd1 : ((x2_q <= -bxs) ? -2'sd1 : 2'sd0);
    gy2 = (y2_q >= bys) ? 2'sd1 : ((y2_q <= -bys) ? -2'sd1 : 2'sd0);
    inbox_d = (gx1 == 2'sd0 && gy1 == 2'sd0) || (gx2 == 2'sd0 && gy2 == 2'sd0);

    fx1_d = x1_q;
    fy1_d = y1_q;
    fx2_d = x2_q;
    fy2_d = y2_q;
    fbx_d = hl_q;
    fby_d = hw_q;

    // mirror x, then y, so the start point sits on the positive side
    if (gx1 < 2'sd0 || (gx1 == 2'sd0 && gx2 < 2'sd0)) begin
      fx1_d = -fx1_d;
      fx2_d = -fx2_d;
      gx1   = -gx1;
      gx2   = -gx2;
    end
    if (gy1 < 2'sd0 || (gy1 == 2'sd0 && gy2 < 2'sd0)) begin
      fy1_d = -fy1_d;
      fy2_d = -fy2_d;
      gy1   = -gy1;
      gy2   = -gy2;
    end
    // swap axes
    if (gx1 < gy1 || (gx1 == gy1 && gx2 < gy2)) begin
      tx = fx1_d; fx1_d = fy1_d; fy1_d = tx;
      tx = fx2_d; fx2_d = fy2_d; fy2_d = tx;
      tb = fbx_d; fbx_d = fby_d; fby_d = tb;
      tg = gx1;   gx1   = gy1;   gy1   = tg;
      tg = gx2;   gx2   = gy2;   gy2   = tg;
    end

    // region table; corner A is (bx, -by) for a corner start, else (bx, by)
    aneg_d = (gx1 == 2'sd1) && (gy1 == 2'sd1);
    dec_d  = DEC_TRUE;
    if (aneg_d) begin
      if (gx2 == 2'sd1) begin
        dec_d = DEC_FALSE;                                   // end right of box
      end else if (gx2 == 2'sd0 && gy2 == -2'sd1) begin
        dec_d = DEC_A_GE;                                    // end below box
      end else if (gx2 == -2'sd1 && gy2 == -2'sd1) begin
        dec_d = DEC_AB;                                      // end at opposite corner
      end
    end else begin
      if (gx2 == 2'sd1 && (gy2 == 2'sd1 || gy2 == 2'sd0)) begin
        dec_d = DEC_FALSE;
      end else if ((gx2 == 2'sd0 && gy2 == 2'sd1) ||
                   (gx2 == -2'sd1 && gy2 == 2'sd1)) begin
        dec_d = DEC_A_LE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mx2_q   <= mxp[SW-1:0];
    my2_q   <= myp[SW-1:0];
    dx2_q   <= dxp[2*CW-1:0];
    dy2_q   <= dyp[2*CW-1:0];
    hl2_q   <= hl2_d;
    hw2_q   <= hw2_d;
    fx1_q   <= fx1_d;
    fy1_q   <= fy1_d;
    fx2_q   <= fx2_d;
    fy2_q   <= fy2_d;
    fbx_q   <= fbx_d;
    fby_q   <= fby_d;
    pin_q   <= pin_d;
    inbox_q <= inbox_d;
    aneg_q  <= aneg_d;
    dec_q   <= dec_d;
  end

  logic zero2_q;
  always_ff @(posedge clk_i) begin
    zero2_q <= zero_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: distance-bound sums, cross-product operands
  // ---------------------------------------------------------------------------
  logic [SW-1:0]     lhs_d, rhs_d, lhs_q, rhs_q;
  logic [2*CW-2:0]   hsum;
  logic [2*CW:0]     dsum;
  logic signed [OW-1:0] ux_d, uy_d, ax_d, ay_d, bx_d, by_d;
  logic signed [OW-1:0] ux_q, uy_q, ax_q, ay_q, bx_q, by_q;

  always_comb begin
    logic signed [OW-1:0] x1e, y1e, bxe, bye;
    hsum  = {1'b0, hl2_q} + {1'b0, hw2_q};
    dsum  = {1'b0, dx2_q} + {1'b0, dy2_q};
    lhs_d = mx2_q + my2_q;
    rhs_d = {1'b0, hsum, 3'b000} + {1'b0, dsum, 1'b0};

    x1e  = {fx1_q[XW-1], fx1_q};
    y1e  = {fy1_q[XW-1], fy1_q};
    bxe  = {3'b000, fbx_q};
    bye  = {3'b000, fby_q};
    ux_d = {fx2_q[XW-1], fx2_q} - x1e;
    uy_d = {fy2_q[XW-1], fy2_q} - y1e;
    ax_d = bxe - x1e;
    ay_d = (aneg_q ? -bye : bye) - y1e;
    bx_d = -bxe - x1e;                                        // corner B = (-bx, by)
    by_d = bye - y1e;
  end

  logic pin3_q, inbox3_q, zero3_q;
  dec_e dec3_q;

  always_ff @(posedge clk_i) begin
    lhs_q    <= lhs_d;
    rhs_q    <= rhs_d;
    ux_q     <= ux_d;
    uy_q     <= uy_d;
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    bx_q     <= bx_d;
    by_q     <= by_d;
    pin3_q   <= pin_q;
    inbox3_q <= inbox_q;
    zero3_q  <= zero2_q;
    dec3_q   <= dec_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: cross products, distance reject
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] pa1_q, pa2_q, pb1_q, pb2_q;
  logic                 reject_q, pin4_q, inbox4_q, zero4_q;
  dec_e                 dec4_q;

  always_ff @(posedge clk_i) begin
    pa1_q    <= ux_q * ay_q;
    pa2_q    <= uy_q * ax_q;
    pb1_q    <= ux_q * by_q;
    pb2_q    <= uy_q * bx_q;
    reject_q <= lhs_q > rhs_q;
    pin4_q   <= pin3_q;
    inbox4_q <= inbox3_q;
    zero4_q  <= zero3_q;
    dec4_q   <= dec3_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: cross signs, final decision into the output register
  // ---------------------------------------------------------------------------
  logic signed [PW:0] ca, cb;
  logic               hit_d, hit_q;

  always_comb begin
    ca = {pa1_q[PW-1], pa1_q} - {pa2_q[PW-1], pa2_q};
    cb = {pb1_q[PW-1], pb1_q} - {pb2_q[PW-1], pb2_q};
    priority if (zero4_q) begin
      hit_d = pin4_q;
    end else if (reject_q) begin
      hit_d = 1'b0;
    end else if (inbox4_q) begin
      hit_d = 1'b1;
    end else begin
      unique case (dec4_q)
        DEC_FALSE: hit_d = 1'b0;
        DEC_A_GE:  hit_d = !ca[PW];
        DEC_A_LE:  hit_d = ca[PW] || (ca == '0);
        DEC_AB:    hit_d = !ca[PW] && (ca != '0) && (cb[PW] || (cb == '0));
        default:   hit_d = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  assign res_valid_o = vo_q;
  assign overlaps_o  = hit_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // every accepted beat yields exactly one result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 res_valid_o)
    else $error("accepted segment produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##5 !res_valid_o)
    else $error("result without an accepted segment");

endmodule
